[rtl/core/fwslq_pkg.sv]
// ----------------------------------------------------------------------------
// fwslq_pkg: shared types and constants of the four-way signal core
// Queue geometry, field widths, event and phase codes, request views.
// ----------------------------------------------------------------------------
`default_nettype none

package fwslq_pkg;

  // Queue geometry.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned LANE_COUNT  = 4;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LANE_W  = $clog2(LANE_COUNT);
  localparam int unsigned SLOTS   = LANE_COUNT * QUEUE_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(SLOTS);

  // Field widths.
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned VID_W      = 16;
  localparam int unsigned ENTRY_W    = TICK_W + VID_W;
  localparam int unsigned TIMER_W    = 8;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned QC_W       = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_USED_W   = 2 + VID_W + TICK_W + QC_W + 2 + 2 + 2 * TOTAL_W;
  localparam int unsigned M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
  localparam int unsigned M_TUSER_W  = 2;

  // Register reset values.
  localparam logic [TIMER_W-1:0] GREEN_RESET   = 8'd5;
  localparam logic [TIMER_W-1:0] YELLOW_RESET  = 8'd1;
  localparam logic [TIMER_W-1:0] ALL_RED_RESET = 8'd1;

  typedef enum logic [1:0] {
    EV_TICK    = 2'd0,
    EV_DEPART  = 2'd1,
    EV_QUEUED  = 2'd2,
    EV_DROPPED = 2'd3
  } event_res_e;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    LIGHT_RED    = 2'd0,
    LIGHT_YELLOW = 2'd1,
    LIGHT_GREEN  = 2'd2
  } light_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GREEN   = 2'd0,
    CFG_YELLOW  = 2'd1,
    CFG_ALL_RED = 2'd2
  } cfg_reg_e;

  // Signal controller view handed to the queue logic.
  typedef struct packed {
    logic [LANE_W-1:0] served;      // served lane before the request
    logic              green;       // served lane is green before the request
    logic [1:0]        next_lane;   // served lane after the request
    light_e            next_light;  // light after the request
  } sig_view_t;

  // First-stage result, waiting for the queue memory read data.
  typedef struct packed {
    event_res_e          res;
    logic [1:0]          ev_lane;
    logic [VID_W-1:0]    vehicle;
    logic [TICK_W-1:0]   now_tick;
    logic [QC_W-1:0]     qc;
    logic [1:0]          green_lane;
    light_e              light;
    logic [TOTAL_W-1:0]  total_q;
    logic [TOTAL_W-1:0]  total_d;
  } stage_t;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [LANE_W-1:0] lane,
                                                  logic [PTR_W-1:0] ptr);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(lane) * ADDR_W'(QUEUE_DEPTH));
    return ADDR_W'(base + ADDR_W'(ptr));
  endfunction

endpackage

`default_nettype wire

[rtl/core/four_way_signal_with_lane_queues_core.sv]
// ----------------------------------------------------------------------------
// four_way_signal_with_lane_queues_core: four-way signal with lane queues
// Round-robin signal controller with one vehicle FIFO per lane.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+-----------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser action, tdata lane,id
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tuser event, tdata result
//  cfg      | in        | cfg_valid_i/cfg_ready_o      | index, 8-bit timing value
//
//  A request enters every cycle while s_axis_tready is high; its result
//  passes the result stage, which takes the registered queue memory read,
//  into the output register. Reset clears all queues, the phase and the
//  totals at once; the queue memory needs no clearing pass. A stall on
//  m_axis first fills the output register and then the result stage,
//  after which s_axis_tready drops. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module four_way_signal_with_lane_queues_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [fwslq_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // lane, vehicle
  input  wire logic [0:0]                            s_axis_tuser,  // action
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // event_lane, event_vehicle, wait_ticks, queue_count, green_lane, light,
  // total_queued, total_departed
  output logic      [fwslq_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic      [fwslq_pkg::M_TUSER_W-1:0]       m_axis_tuser,  // event_res
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [fwslq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fwslq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic                             accept;
  logic                             tick;
  fwslq_pkg::sig_view_t             view;
  fwslq_pkg::stage_t                stage;
  logic                             mem_we, mem_re;
  logic [fwslq_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [fwslq_pkg::ENTRY_W-1:0]    mem_wdata, mem_rdata;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign tick        = accept & ~s_axis_tuser[0];
  assign cfg_ready_o = 1'b1;

  fwslq_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .view_o      (view)
  );

  fwslq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .arrival_i   (s_axis_tuser[0]),
    .lane_i      (s_axis_tdata[1:0]),
    .vehicle_i   (s_axis_tdata[17:2]),
    .view_i      (view),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .stage_o     (stage)
  );

  fwslq_ram #(
    .WIDTH (fwslq_pkg::ENTRY_W),
    .DEPTH (fwslq_pkg::SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fwslq_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .stage_i     (stage),
    .mem_rdata_i (mem_rdata),
    .in_ready_o  (s_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

[rtl/core/fwslq_ram.sv]
// ----------------------------------------------------------------------------
// fwslq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwslq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/fwslq_phase.sv]
// ----------------------------------------------------------------------------
// fwslq_phase: signal phase sequencer
// Holds the timing registers and steps green, yellow and all-red per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module fwslq_phase (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                tick_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [fwslq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [fwslq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output fwslq_pkg::sig_view_t                     view_o
);

  localparam int unsigned LW = fwslq_pkg::LANE_W;
  localparam int unsigned TW = fwslq_pkg::TIMER_W;

  fwslq_pkg::phase_e phase_q, phase_d, ph_w;
  logic [TW-1:0]     timer_q, timer_d, tm_w;
  logic [LW-1:0]     served_q, served_d, ln_w;
  logic              done_w;
  logic [TW-1:0]     green_len_q, yellow_len_q, red_len_q;
  fwslq_pkg::light_e light_d;

  function automatic logic [LW-1:0] lane_next(logic [LW-1:0] ln);
    return (ln == LW'(fwslq_pkg::LANE_COUNT - 1)) ? '0 : LW'(ln + 1'b1);
  endfunction

  // Green always lasts at least one tick.
  function automatic logic [TW-1:0] phase_len(fwslq_pkg::phase_e ph,
                                              logic [TW-1:0] g,
                                              logic [TW-1:0] y,
                                              logic [TW-1:0] r);
    logic [TW-1:0] len;
    unique case (ph)
      fwslq_pkg::PH_GREEN:  len = (g == '0) ? TW'(1) : g;
      fwslq_pkg::PH_YELLOW: len = y;
      default:              len = r;
    endcase
    return len;
  endfunction

  // Timing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_len_q  <= fwslq_pkg::GREEN_RESET;
      yellow_len_q <= fwslq_pkg::YELLOW_RESET;
      red_len_q    <= fwslq_pkg::ALL_RED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fwslq_pkg::CFG_GREEN:   green_len_q  <= cfg_data_i;
        fwslq_pkg::CFG_YELLOW:  yellow_len_q <= cfg_data_i;
        fwslq_pkg::CFG_ALL_RED: red_len_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state: a phase of zero length is passed through within the same
  // tick, so up to three transitions can chain before green holds.
  always_comb begin
    ph_w   = phase_q;
    tm_w   = TW'(timer_q + 1'b1);
    ln_w   = served_q;
    done_w = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!done_w && (tm_w >= phase_len(ph_w, green_len_q, yellow_len_q, red_len_q))) begin
        tm_w = '0;
        unique case (ph_w)
          fwslq_pkg::PH_GREEN:  ph_w = fwslq_pkg::PH_YELLOW;
          fwslq_pkg::PH_YELLOW: ph_w = fwslq_pkg::PH_RED;
          fwslq_pkg::PH_RED: begin
            ph_w = fwslq_pkg::PH_GREEN;
            ln_w = lane_next(ln_w);
          end
          default:              ph_w = fwslq_pkg::PH_GREEN;
        endcase
      end else begin
        done_w = 1'b1;
      end
    end
    if (tick_i) begin
      phase_d  = ph_w;
      timer_d  = tm_w;
      served_d = ln_w;
    end else begin
      phase_d  = phase_q;
      timer_d  = timer_q;
      served_d = served_q;
    end
  end

  // Outputs.
  always_comb begin
    unique case (phase_d)
      fwslq_pkg::PH_GREEN:  light_d = fwslq_pkg::LIGHT_GREEN;
      fwslq_pkg::PH_YELLOW: light_d = fwslq_pkg::LIGHT_YELLOW;
      default:              light_d = fwslq_pkg::LIGHT_RED;
    endcase
    view_o.served     = served_q;
    view_o.green      = (phase_q == fwslq_pkg::PH_GREEN);
    view_o.next_lane  = 2'(served_d);
    view_o.next_light = light_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fwslq_pkg::PH_GREEN;
      timer_q  <= '0;
      served_q <= '0;
    end else begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      served_q <= served_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fwslq_queue.sv]
// ----------------------------------------------------------------------------
// fwslq_queue: lane queue bookkeeping
// Head, tail and fill count per lane, tick counter, totals, memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module fwslq_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              arrival_i,
  input  wire logic [1:0]                        lane_i,
  input  wire logic [fwslq_pkg::VID_W-1:0]       vehicle_i,
  input  fwslq_pkg::sig_view_t                   view_i,
  output logic                                   mem_we_o,
  output logic      [fwslq_pkg::ADDR_W-1:0]      mem_waddr_o,
  output logic      [fwslq_pkg::ENTRY_W-1:0]     mem_wdata_o,
  output logic                                   mem_re_o,
  output logic      [fwslq_pkg::ADDR_W-1:0]      mem_raddr_o,
  output fwslq_pkg::stage_t                      stage_o
);

  localparam int unsigned NL = fwslq_pkg::LANE_COUNT;
  localparam int unsigned PW = fwslq_pkg::PTR_W;
  localparam int unsigned CW = fwslq_pkg::CNT_W;
  localparam int unsigned LW = fwslq_pkg::LANE_W;

  logic [PW-1:0] head_q [NL];
  logic [PW-1:0] head_d [NL];
  logic [PW-1:0] tail_q [NL];
  logic [PW-1:0] tail_d [NL];
  logic [CW-1:0] cnt_q  [NL];
  logic [CW-1:0] cnt_d  [NL];

  logic [fwslq_pkg::TICK_W-1:0]  now_q, now_d;
  logic [fwslq_pkg::TOTAL_W-1:0] tq_q, tq_d, td_q, td_d;

  logic [LW-1:0] lane_idx;
  logic          lane_ok;
  logic          do_write, do_read;

  function automatic logic [PW-1:0] ring_next(logic [PW-1:0] p);
    return (p == PW'(fwslq_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign lane_idx = LW'(lane_i);
  assign lane_ok  = (32'(lane_i) < 32'(NL));

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    now_d    = now_q;
    tq_d     = tq_q;
    td_d     = td_q;
    do_write = 1'b0;
    do_read  = 1'b0;

    mem_waddr_o = fwslq_pkg::slot_addr(lane_idx, tail_q[lane_idx]);
    mem_wdata_o = {now_q, vehicle_i};
    mem_raddr_o = fwslq_pkg::slot_addr(view_i.served, head_q[view_i.served]);

    stage_o.res        = fwslq_pkg::EV_TICK;
    stage_o.ev_lane    = 2'(view_i.served);
    stage_o.vehicle    = '0;
    stage_o.now_tick   = now_q;
    stage_o.qc         = '0;
    stage_o.green_lane = view_i.next_lane;
    stage_o.light      = view_i.next_light;

    if (arrival_i) begin
      stage_o.ev_lane = lane_i;
      stage_o.vehicle = vehicle_i;
      if (!lane_ok) begin
        stage_o.res = fwslq_pkg::EV_DROPPED;
      end else if (cnt_q[lane_idx] == CW'(fwslq_pkg::QUEUE_DEPTH)) begin
        stage_o.res = fwslq_pkg::EV_DROPPED;
        stage_o.qc  = fwslq_pkg::QC_W'(cnt_q[lane_idx]);
      end else begin
        do_write         = 1'b1;
        tail_d[lane_idx] = ring_next(tail_q[lane_idx]);
        cnt_d[lane_idx]  = CW'(cnt_q[lane_idx] + 1'b1);
        tq_d             = fwslq_pkg::TOTAL_W'(tq_q + 1'b1);
        stage_o.res      = fwslq_pkg::EV_QUEUED;
        stage_o.qc       = fwslq_pkg::QC_W'(cnt_d[lane_idx]);
      end
    end else begin
      if (view_i.green && (cnt_q[view_i.served] != '0)) begin
        do_read                = 1'b1;
        head_d[view_i.served]  = ring_next(head_q[view_i.served]);
        cnt_d[view_i.served]   = CW'(cnt_q[view_i.served] - 1'b1);
        td_d                   = fwslq_pkg::TOTAL_W'(td_q + 1'b1);
        stage_o.res            = fwslq_pkg::EV_DEPART;
      end
      stage_o.qc = fwslq_pkg::QC_W'(cnt_d[view_i.served]);
      now_d      = fwslq_pkg::TICK_W'(now_q + 1'b1);
    end

    stage_o.total_q = tq_d;
    stage_o.total_d = td_d;
  end

  assign mem_we_o = accept_i & do_write;
  assign mem_re_o = accept_i & do_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      now_q <= '0;
      tq_q  <= '0;
      td_q  <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      now_q  <= now_d;
      tq_q   <= tq_d;
      td_q   <= td_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fwslq_outreg.sv]
// ----------------------------------------------------------------------------
// fwslq_outreg: result stage and output register
// Joins the first-stage result with the memory read data and drives the
// result stream through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwslq_outreg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  fwslq_pkg::stage_t                        stage_i,
  input  wire logic [fwslq_pkg::ENTRY_W-1:0]       mem_rdata_i,
  output logic                                     in_ready_o,
  output logic                                     m_valid_o,
  input  wire logic                                m_ready_i,
  output logic      [fwslq_pkg::M_TDATA_W-1:0]     m_tdata_o,
  output logic      [fwslq_pkg::M_TUSER_W-1:0]     m_tuser_o
);

  localparam int unsigned PAD_W = fwslq_pkg::M_TDATA_W - fwslq_pkg::M_USED_W;
  localparam int unsigned VW    = fwslq_pkg::VID_W;
  localparam int unsigned TKW   = fwslq_pkg::TICK_W;

  fwslq_pkg::stage_t s1_q;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              s1_move;
  logic [VW-1:0]     vehicle_w;
  logic [TKW-1:0]    wait_w;

  logic [fwslq_pkg::M_TDATA_W-1:0] tdata_q, tdata_d;
  logic [fwslq_pkg::M_TUSER_W-1:0] tuser_q, tuser_d;

  assign s1_move    = !out_valid_q || m_ready_i;
  assign in_ready_o = !s1_valid_q || s1_move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = s1_valid_q;
    end
  end

  // Departed vehicles take their id and arrival tick from the memory.
  always_comb begin
    if (s1_q.res == fwslq_pkg::EV_DEPART) begin
      vehicle_w = mem_rdata_i[VW-1:0];
      wait_w    = TKW'(s1_q.now_tick - mem_rdata_i[fwslq_pkg::ENTRY_W-1:VW]);
    end else begin
      vehicle_w = s1_q.vehicle;
      wait_w    = '0;
    end
    tdata_d = {PAD_W'(0), s1_q.total_d, s1_q.total_q, s1_q.light, s1_q.green_lane,
               s1_q.qc, wait_w, vehicle_w, s1_q.ev_lane};
    tuser_d = s1_q.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= stage_i;
    end
    if (s1_move && s1_valid_q) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_tdata_o = tdata_q;
  assign m_tuser_o = tuser_q;

endmodule

`default_nettype wire

[rtl/core/fwslq_checker.sv]
// ----------------------------------------------------------------------------
// fwslq_checker: port-level checks for the four-way signal core
// Watches the result stream for stalls and consistent event fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fwslq_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [fwslq_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input wire logic [fwslq_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

  logic [15:0] vehicle;
  logic [15:0] wait_t;
  logic [4:0]  qc;

  assign vehicle = m_axis_tdata[17:2];
  assign wait_t  = m_axis_tdata[33:18];
  assign qc      = m_axis_tdata[38:34];

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A queued vehicle leaves its lane non-empty and has no wait yet.
  a_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fwslq_pkg::EV_QUEUED) |->
      (qc != 5'd0) && (wait_t == 16'd0))
    else $error("queued event with empty lane or nonzero wait");

  // A departure always leaves room in its lane.
  a_depart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fwslq_pkg::EV_DEPART) |->
      (32'(qc) < 32'(fwslq_pkg::QUEUE_DEPTH)))
    else $error("departure left a full lane");

  // A tick without departure carries no vehicle and no wait.
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fwslq_pkg::EV_TICK) |->
      (vehicle == 16'd0) && (wait_t == 16'd0))
    else $error("idle tick reported a vehicle");

endmodule

bind four_way_signal_with_lane_queues_core fwslq_checker u_checker (.*);

`default_nettype wire
